/* src/knn_topk_majority_vote_unit_macros.svh */
// assertion helpers for the knn vote unit
// each expects signals named clk and rst in the scope that uses it
`ifndef KNN_TOPK_MAJORITY_VOTE_UNIT_MACROS_SVH
`define KNN_TOPK_MAJORITY_VOTE_UNIT_MACROS_SVH

// property that must hold in the same cycle
`define KMV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// property that must hold in the following cycle
`define KMV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/kmv_pkg.sv */
// ---------------------------------------------------------------------------
// kmv_pkg
// Shared types and constants of the knn top-k majority vote unit.
// ---------------------------------------------------------------------------
`default_nettype none

package kmv_pkg;

  localparam int MAX_NEIGHBOURS = 16;
  localparam int CLASS_COUNT    = 16;
  localparam int DISTANCE_BITS  = 32;

  localparam int CNT_W   = $clog2(MAX_NEIGHBOURS + 1);
  localparam int CLASS_W = 4;
  localparam int ADDR_W  = 3;

  // register index, taken from paddr[ADDR_W-1:2]
  localparam logic [ADDR_W-3:0] REG_NEIGHBOUR_COUNT = '0;

  typedef struct packed {
    logic [DISTANCE_BITS-1:0] distance;
    logic [CLASS_W-1:0]       class_label;
    logic                     last;
  } in_word_t;

  typedef struct packed {
    logic [CLASS_W-1:0] winning_class;
    logic [CNT_W-1:0]   winning_votes;
  } out_word_t;

  // one kept neighbour
  typedef struct packed {
    logic [DISTANCE_BITS-1:0] key;
    logic [CLASS_W-1:0]       cls;
  } entry_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;    // insert the new word into the sorted row
    logic grow;   // insertion adds one occupied cell
    logic drain;  // shift the row toward cell 0 for the vote
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_DRAIN,
    ST_REPORT
  } state_t;

endpackage

`default_nettype wire

/* src/kmv_cell.sv */
// ---------------------------------------------------------------------------
// kmv_cell
// One slot of the sorted neighbour row: compares the new word against its
// own distance, takes the new word or its left neighbour on insertion, and
// takes its right neighbour while the row drains.
// ---------------------------------------------------------------------------
`default_nettype none

module kmv_cell (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire kmv_pkg::cell_ctrl_t ctrl,
  input  wire kmv_pkg::entry_t     item_entry,
  input  wire logic                prev_keep,
  input  wire logic                prev_valid,
  input  wire kmv_pkg::entry_t     prev_entry,
  input  wire logic                next_valid,
  input  wire kmv_pkg::entry_t     next_entry,
  output logic                     keep,
  output logic                     valid,
  output kmv_pkg::entry_t          entry
);

  // equal distances stay ahead of the new word
  assign keep = valid && (entry.key <= item_entry.key);

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.drain) begin
      valid <= next_valid;
    end else if (ctrl.ins && ctrl.grow) begin
      valid <= prev_valid;
    end
  end

  // contents
  always_ff @(posedge clk) begin
    if (ctrl.drain) begin
      entry <= next_entry;
    end else if (ctrl.ins && !keep) begin
      entry <= prev_keep ? item_entry : prev_entry;
    end
  end

endmodule

`default_nettype wire

/* src/knn_topk_majority_vote_unit.sv */
// ---------------------------------------------------------------------------
// knn_topk_majority_vote_unit
// Keeps the k nearest neighbours of a query in a sorted row of cells and
// reports the majority class once the last instance has been taken in.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake                 | word
//  ---------+-----------+---------------------------+---------------------------
//  item     | in        | item_valid / item_stall   | distance, class_label, last
//  result   | out       | result_valid / result_stall | winning_class, winning_votes
//  config   | in        | apb psel / penable        | neighbour_count at 0x0
//
//  one instance word per cycle while a query is collected
//  the word marked last starts the vote: the row of n kept neighbours (at most
//  16) shifts out past the tally, then the report step loads the result
//  item_stall is high from the vote until the result register is loaded
//  a stalled result holds the unit in its report step
//  synchronous active-high reset empties the row, tally and result register
// ---------------------------------------------------------------------------
`default_nettype none

module knn_topk_majority_vote_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              item_valid,
  output logic                                   item_stall,
  input  wire kmv_pkg::in_word_t                 item,
  output logic                                   result_valid,
  input  wire logic                              result_stall,
  output kmv_pkg::out_word_t                     result,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [kmv_pkg::ADDR_W-1:0]        paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);

  localparam int N = kmv_pkg::MAX_NEIGHBOURS;
  localparam int CW = kmv_pkg::CNT_W;

  kmv_pkg::state_t     state, state_next;
  kmv_pkg::cell_ctrl_t ctrl;
  kmv_pkg::entry_t     item_entry;
  kmv_pkg::entry_t     cell_entry [N];
  logic [N-1:0]        cell_keep;
  logic [N-1:0]        cell_valid;

  logic [CW-1:0]                   neighbour_count;
  logic [CW-1:0]                   k_eff;
  logic [CW-1:0]                   filled;
  logic [CW-1:0]                   tally [kmv_pkg::CLASS_COUNT];
  logic [kmv_pkg::CLASS_W-1:0]     best_cls;
  logic [CW-1:0]                   best_votes;
  logic [CW-1:0]                   tally_inc;
  logic [kmv_pkg::CLASS_W-1:0]     vote_cls;
  logic                            accept;
  logic                            grow;
  logic                            any_greater;
  logic                            load;
  logic                            cfg_hit;

  // apb register
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[kmv_pkg::ADDR_W-1:2] == kmv_pkg::REG_NEIGHBOUR_COUNT);
  assign prdata  = cfg_hit ? 32'(neighbour_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      neighbour_count <= CW'(1);
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      neighbour_count <= pwdata[CW-1:0];
    end
  end

  // effective k: zero means one, large values saturate
  always_comb begin
    if (neighbour_count == '0) begin
      k_eff = CW'(1);
    end else if (neighbour_count > CW'(N)) begin
      k_eff = CW'(N);
    end else begin
      k_eff = neighbour_count;
    end
  end

  // insertion decision
  assign item_stall  = (state != kmv_pkg::ST_COLLECT);
  assign accept      = item_valid && !item_stall;
  assign grow        = (filled < k_eff);
  assign any_greater = |(cell_valid & ~cell_keep);
  assign item_entry  = '{key: item.distance, cls: item.class_label};

  always_comb begin
    ctrl.grow  = grow;
    ctrl.ins   = accept && (grow || any_greater);
    ctrl.drain = (state == kmv_pkg::ST_DRAIN);
  end

  // sorted row of cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic            prev_keep;
    logic            prev_valid;
    logic            next_valid;
    kmv_pkg::entry_t prev_entry;
    kmv_pkg::entry_t next_entry;

    if (i == 0) begin : g_head
      assign prev_keep  = 1'b1;
      assign prev_valid = 1'b1;
      assign prev_entry = item_entry;
    end else begin : g_body
      assign prev_keep  = cell_keep[i-1];
      assign prev_valid = cell_valid[i-1];
      assign prev_entry = cell_entry[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign next_valid = 1'b0;
      assign next_entry = '0;
    end else begin : g_inner
      assign next_valid = cell_valid[i+1];
      assign next_entry = cell_entry[i+1];
    end

    kmv_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .item_entry (item_entry),
      .prev_keep  (prev_keep),
      .prev_valid (prev_valid),
      .prev_entry (prev_entry),
      .next_valid (next_valid),
      .next_entry (next_entry),
      .keep       (cell_keep[i]),
      .valid      (cell_valid[i]),
      .entry      (cell_entry[i])
    );
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
    end else if (ctrl.drain) begin
      filled <= filled - CW'(1);
    end else if (ctrl.ins && grow) begin
      filled <= filled + CW'(1);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kmv_pkg::ST_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    load       = 1'b0;
    unique case (state)
      kmv_pkg::ST_COLLECT: begin
        if (accept && item.last) state_next = kmv_pkg::ST_DRAIN;
      end
      kmv_pkg::ST_DRAIN: begin
        if (filled == CW'(1)) state_next = kmv_pkg::ST_REPORT;
      end
      kmv_pkg::ST_REPORT: begin
        if (!result_valid || !result_stall) begin
          load       = 1'b1;
          state_next = kmv_pkg::ST_COLLECT;
        end
      end
      default: state_next = kmv_pkg::ST_COLLECT;
    endcase
  end

  // tally of the class leaving cell 0, running best with lowest class on ties
  assign vote_cls  = cell_entry[0].cls;
  assign tally_inc = tally[vote_cls] + CW'(1);

  always_ff @(posedge clk) begin
    if (rst || load) begin
      for (int c = 0; c < kmv_pkg::CLASS_COUNT; c++) tally[c] <= '0;
      best_cls   <= '0;
      best_votes <= '0;
    end else if (ctrl.drain) begin
      tally[vote_cls] <= tally_inc;
      if (tally_inc > best_votes || (tally_inc == best_votes && vote_cls < best_cls)) begin
        best_cls   <= vote_cls;
        best_votes <= tally_inc;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= '{winning_class: best_cls, winning_votes: best_votes};
    end
  end

endmodule

`default_nettype wire

/* src/kmv_checker.sv */
// ---------------------------------------------------------------------------
// kmv_checker
// Port-level checks of the knn vote unit, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "knn_topk_majority_vote_unit_macros.svh"

module kmv_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               item_valid,
  input wire logic               item_stall,
  input wire kmv_pkg::in_word_t  item,
  input wire logic               result_valid,
  input wire logic               result_stall,
  input wire kmv_pkg::out_word_t result
);

  // a stalled result stays offered
  `KMV_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid, "result dropped")

  // the vote always counts at least one neighbour
  `KMV_ASSERT_NOW(a_votes_nonzero, result_valid, result.winning_votes != '0, "empty vote")

  // no class can hold more votes than there are cells
  `KMV_ASSERT_NOW(a_votes_bound, result_valid,
                  result.winning_votes <= 5'(kmv_pkg::MAX_NEIGHBOURS), "vote count too large")

  // the word marked last closes the query and blocks input during the vote
  `KMV_ASSERT_NEXT(a_busy_after_last, item_valid && !item_stall && item.last, item_stall,
                   "input taken during vote")

endmodule

bind knn_topk_majority_vote_unit kmv_checker u_kmv_checker (.*);

`default_nettype wire
